// ===== src/rrid_pkg.sv =====
// Package of the row-wise RLE image decoder: field widths, sizing constants,
// configuration register indexes, the phase encoding and the result record.
// No dependencies.
`default_nettype none
package rrid_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;

	localparam int PIX_W   = 8;
	localparam int POS_W   = 8;
	localparam int LEN_W   = 9;
	localparam int DIM_W   = 9;
	localparam int BYTES_W = 16;
	localparam int PEND_W  = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int MAX_RES  = 3;
	localparam int RES_CNT_W = 2;
	localparam int RQ_DEPTH = 4;
	localparam int RQ_IDX_W = 2;
	localparam int RQ_CNT_W = 3;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_DATA  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_PAYLOAD_SIZE = 2'd2
	} cfg_index_t;

	typedef enum logic [7:0] {
		PH_WAIT      = 8'b0000_0001,
		PH_HDR_LO    = 8'b0000_0010,
		PH_HDR_HI    = 8'b0000_0100,
		PH_CODE      = 8'b0000_1000,
		PH_FILL      = 8'b0001_0000,
		PH_LIT       = 8'b0010_0000,
		PH_SKIP_LINE = 8'b0100_0000,
		PH_SKIP_TAIL = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
		logic [POS_W-1:0] start_row;
		logic [POS_W-1:0] start_column;
		logic [LEN_W-1:0] run_length;
		logic [LEN_W-1:0] row_span;
		logic             image_done;
	} result_t;

endpackage
`default_nettype wire

// ===== src/rrid_in_if.sv =====
// Input channel of the RLE image decoder: valid, ready and one input item.
// Depends on rrid_pkg for the field widths.
`default_nettype none
interface rrid_in_if;
	import rrid_pkg::*;

	logic             valid;
	logic             ready;
	logic             mode;
	logic [PIX_W-1:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink (input valid, input mode, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== src/rrid_out_if.sv =====
// Output channel of the RLE image decoder: valid, ready and one pixel run.
// Depends on rrid_pkg for the field widths.
`default_nettype none
interface rrid_out_if;
	import rrid_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;
	logic [POS_W-1:0] start_row;
	logic [POS_W-1:0] start_column;
	logic [LEN_W-1:0] run_length;
	logic [LEN_W-1:0] row_span;
	logic             image_done;

	modport source (output valid, output pixel_value, output start_row,
		output start_column, output run_length, output row_span,
		output image_done, input ready);
	modport sink (input valid, input pixel_value, input start_row,
		input start_column, input run_length, input row_span,
		input image_done, output ready);
endinterface
`default_nettype wire

// ===== src/rle_row_image_decoder_unit.sv =====
// Top level of the row-wise RLE image decoder: parser state, run generation
// and a four-entry result queue. Depends on rrid_pkg, rrid_in_if, rrid_out_if.
//
//   channel     dir   handshake        one beat carries
//   in_item     in    valid/ready      mode, data_byte
//   out_result  out   valid/ready      pixel_value, start_row, start_column,
//                                      run_length, row_span, image_done
//   cfg         in    cfg_write        cfg_index, cfg_data (no read-back)
//
// Each input beat is decoded in the cycle it is accepted, one beat per cycle.
// A beat yields zero to three runs, written at once into the result queue.
// The queue drains one run per cycle while out_result is ready; input is taken
// while at most one entry is occupied, so two queued runs stall the input.
// Reset clears the parser state and empties the queue; no clearing pass.
`default_nettype none
module rle_row_image_decoder_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_write,
	input  wire [rrid_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [rrid_pkg::CFG_DATA_W-1:0]    cfg_data,
	rrid_in_if.sink                           in_item,
	rrid_out_if.source                        out_result
);
	import rrid_pkg::*;

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [BYTES_W-1:0] psize_q;

	phase_t             ph_q, ph_n;
	logic [BYTES_W-1:0] bl_q, bl_n;
	logic [BYTES_W-1:0] ll_q, ll_n;
	logic [DIM_W-1:0]   row_q, row_n;
	logic [DIM_W-1:0]   col_q, col_n;
	logic [PEND_W-1:0]  pend_q, pend_n;
	logic [PIX_W-1:0]   hlo_q, hlo_n;

	logic [DIM_W-1:0]   w_eff, h_eff;
	logic [LEN_W-1:0]   len;
	logic [LEN_W:0]     col_end;
	logic [BYTES_W-1:0] bl_dec;
	logic [BYTES_W-1:0] hdr_len;
	logic               do_cont, do_end, do_next, do_begin;
	result_t            res [MAX_RES];
	logic [RES_CNT_W-1:0] n_res;

	result_t            q_q [RQ_DEPTH];
	result_t            q_n [RQ_DEPTH];
	logic [RQ_CNT_W-1:0] cnt_q, cnt_n, base;
	logic               acc, pop;

	function automatic result_t make_res(input logic [PIX_W-1:0] val,
		input logic [DIM_W-1:0] row, input logic [DIM_W-1:0] col,
		input logic [LEN_W-1:0] rlen, input logic [LEN_W-1:0] span,
		input logic done);
		result_t r;
		r.pixel_value  = val;
		r.start_row    = row[POS_W-1:0];
		r.start_column = col[POS_W-1:0];
		r.run_length   = rlen;
		r.row_span     = span;
		r.image_done   = done;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			psize_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				CFG_PAYLOAD_SIZE: psize_q  <= cfg_data[BYTES_W-1:0];
				default: ;
			endcase
		end
	end

	assign w_eff = (width_q == '0) ? DIM_W'(1) :
		(width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
	assign h_eff = (height_q == '0) ? DIM_W'(1) :
		(height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;

	assign acc = in_item.valid && in_item.ready;
	assign pop = out_result.valid && out_result.ready;
	assign in_item.ready = (cnt_q <= RQ_CNT_W'(RQ_DEPTH - MAX_RES));

	always_comb begin
		ph_n     = ph_q;
		bl_n     = bl_q;
		ll_n     = ll_q;
		row_n    = row_q;
		col_n    = col_q;
		pend_n   = pend_q;
		hlo_n    = hlo_q;
		do_cont  = 1'b0;
		do_end   = 1'b0;
		do_next  = 1'b0;
		do_begin = 1'b0;
		n_res    = '0;
		len      = '0;
		col_end  = '0;
		bl_dec   = bl_q - BYTES_W'(1);
		hdr_len  = '0;
		for (int k = 0; k < MAX_RES; k++) begin
			res[k] = '0;
		end

		if (acc) begin
			if (in_item.mode == MODE_START) begin
				bl_n     = psize_q;
				ll_n     = '0;
				row_n    = '0;
				col_n    = '0;
				pend_n   = '0;
				hlo_n    = '0;
				do_begin = 1'b1;
			end else begin
				case (ph_q)
					PH_HDR_LO: begin
						hlo_n = in_item.data_byte;
						bl_n  = bl_dec;
						ph_n  = PH_HDR_HI;
					end
					PH_HDR_HI: begin
						hdr_len = {in_item.data_byte, hlo_q};
						if (hdr_len > bl_dec) begin
							hdr_len = bl_dec;
						end
						ll_n    = hdr_len;
						bl_n    = bl_dec - hdr_len;
						do_cont = 1'b1;
					end
					PH_CODE: begin
						len = {1'b0, in_item.data_byte[7:1]} + LEN_W'(1);
						if (ll_n != '0) begin
							ll_n = ll_n - BYTES_W'(1);
						end
						if (col_q >= w_eff) begin
							do_end = 1'b1;
						end else begin
							col_end = {1'b0, col_q} + {1'b0, len};
							if (col_end > {1'b0, w_eff}) begin
								len = w_eff - col_q;
							end
							if (in_item.data_byte[0]) begin
								pend_n = len[PEND_W-1:0];
								ph_n   = PH_FILL;
							end else begin
								if (BYTES_W'(len) > ll_n) begin
									len = ll_n[LEN_W-1:0];
								end
								ll_n   = ll_n - BYTES_W'(len);
								pend_n = len[PEND_W-1:0];
								if (len == '0) begin
									do_cont = 1'b1;
								end else begin
									ph_n = PH_LIT;
								end
							end
						end
					end
					PH_FILL: begin
						if (ll_n != '0) begin
							ll_n = ll_n - BYTES_W'(1);
						end
						if (col_q < w_eff) begin
							len     = LEN_W'(pend_q);
							col_end = {1'b0, col_q} + {1'b0, len};
							if (col_end > {1'b0, w_eff}) begin
								len = w_eff - col_q;
							end
							if (len != '0) begin
								res[n_res] = make_res(in_item.data_byte, row_q, col_q,
									len, LEN_W'(1), 1'b0);
								n_res = n_res + RES_CNT_W'(1);
							end
							col_n = col_q + len;
						end
						pend_n  = '0;
						do_cont = 1'b1;
					end
					PH_LIT: begin
						if (col_q < w_eff) begin
							res[n_res] = make_res(in_item.data_byte, row_q, col_q,
								LEN_W'(1), LEN_W'(1), 1'b0);
							n_res = n_res + RES_CNT_W'(1);
							col_n = col_q + DIM_W'(1);
						end
						if (pend_n != '0) begin
							pend_n = pend_n - PEND_W'(1);
						end
						if (pend_n == '0) begin
							do_cont = 1'b1;
						end
					end
					PH_SKIP_LINE: begin
						if (ll_n != '0) begin
							ll_n = ll_n - BYTES_W'(1);
						end
						if (ll_n == '0) begin
							do_next = 1'b1;
						end
					end
					PH_SKIP_TAIL: begin
						if (bl_n != '0) begin
							bl_n = bl_n - BYTES_W'(1);
						end
						if (bl_n == '0) begin
							ph_n = PH_WAIT;
						end
					end
					default: ;
				endcase
			end
		end

		if (do_cont) begin
			if (col_n < w_eff && ll_n > BYTES_W'(1)) begin
				ph_n = PH_CODE;
			end else begin
				do_end = 1'b1;
			end
		end

		if (do_end) begin
			if (col_n < w_eff) begin
				res[n_res] = make_res('0, row_n, col_n, w_eff - col_n, LEN_W'(1), 1'b0);
				n_res = n_res + RES_CNT_W'(1);
				col_n = w_eff;
			end
			if (ll_n != '0) begin
				ph_n = PH_SKIP_LINE;
			end else begin
				do_next = 1'b1;
			end
		end

		if (do_next) begin
			row_n    = row_n + DIM_W'(1);
			do_begin = 1'b1;
		end

		if (do_begin) begin
			if (row_n >= h_eff) begin
				if (n_res != '0) begin
					res[n_res - RES_CNT_W'(1)].image_done = 1'b1;
				end else begin
					res[n_res] = make_res('0, h_eff, '0, '0, '0, 1'b1);
					n_res = n_res + RES_CNT_W'(1);
				end
				ph_n = (bl_n != '0) ? PH_SKIP_TAIL : PH_WAIT;
			end else if (bl_n > BYTES_W'(1)) begin
				col_n = '0;
				ph_n  = PH_HDR_LO;
			end else begin
				res[n_res] = make_res('0, row_n, '0, w_eff, h_eff - row_n, 1'b1);
				n_res = n_res + RES_CNT_W'(1);
				row_n = h_eff;
				ph_n  = (bl_n != '0) ? PH_SKIP_TAIL : PH_WAIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_WAIT;
			bl_q   <= '0;
			ll_q   <= '0;
			row_q  <= '0;
			col_q  <= '0;
			pend_q <= '0;
			hlo_q  <= '0;
		end else begin
			ph_q   <= ph_n;
			bl_q   <= bl_n;
			ll_q   <= ll_n;
			row_q  <= row_n;
			col_q  <= col_n;
			pend_q <= pend_n;
			hlo_q  <= hlo_n;
		end
	end

	always_comb begin
		base = cnt_q - RQ_CNT_W'(pop);
		q_n  = q_q;
		if (pop) begin
			for (int i = 0; i < RQ_DEPTH - 1; i++) begin
				q_n[i] = q_q[i + 1];
			end
		end
		if (acc) begin
			for (int k = 0; k < MAX_RES; k++) begin
				if (k < int'(n_res)) begin
					q_n[RQ_IDX_W'(base + RQ_CNT_W'(k))] = res[k];
				end
			end
		end
		cnt_n = base + (acc ? RQ_CNT_W'(n_res) : '0);
	end

	always_ff @(posedge clk) begin
		q_q <= q_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	assign out_result.valid        = (cnt_q != '0);
	assign out_result.pixel_value  = q_q[0].pixel_value;
	assign out_result.start_row    = q_q[0].start_row;
	assign out_result.start_column = q_q[0].start_column;
	assign out_result.run_length   = q_q[0].run_length;
	assign out_result.row_span     = q_q[0].row_span;
	assign out_result.image_done   = q_q[0].image_done;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RQ_CNT_W'(RQ_DEPTH))
		else $error("result queue count beyond its depth");

	a_start_single: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_item.mode == MODE_START |-> n_res <= RES_CNT_W'(1))
		else $error("start beat produced more than one run");

	a_pend_phase: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != '0 |-> (ph_q == PH_FILL || ph_q == PH_LIT))
		else $error("pending run length outside fill or literal phase");

	a_skip_line: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_SKIP_LINE |-> ll_q != '0)
		else $error("line skip with no line bytes left");

	a_skip_tail: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_SKIP_TAIL |-> bl_q != '0)
		else $error("tail skip with no payload bytes left");

endmodule
`default_nettype wire
